>>> hdl/ucld_pkg.sv
// ----------------------------------------------------------------------------
// ucld_pkg
// Types and constants shared by the command line decoder modules.
// ----------------------------------------------------------------------------
package ucld_pkg;

  localparam int unsigned ACK_LEN = 12;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VTAB   = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [6:0] VAL_MAX   = 7'd127;
  localparam logic [6:0] VAL_STOP  = 7'h30;
  localparam logic [6:0] VAL_START = 7'h31;
  localparam logic [6:0] VAL_OFF   = 7'h34;
  localparam logic [6:0] VAL_LON   = 7'h36;
  localparam logic [6:0] VAL_LOFF  = 7'h37;
  localparam logic [6:0] VAL_SHOT  = 7'h38;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_ACK       = 4'd1,
    CMD_STOP_CAL  = 4'd2,
    CMD_START_CAL = 4'd3,
    CMD_OFF       = 4'd4,
    CMD_LASER_ON  = 4'd5,
    CMD_LASER_OFF = 4'd6,
    CMD_SHOT      = 4'd7,
    CMD_UNKNOWN   = 4'd8
  } cmd_t;

  // number parser phase
  typedef enum logic [3:0] {
    PH_BLANK = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_BAD   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       zero_seen;
    logic [3:0] ack_pos;
    logic       ack_bad;
    phase_t     phase;
    logic       negative;
    logic [6:0] value;
    logic       too_large;
  } parse_t;

  localparam parse_t PARSE_CLEAR = '{
    zero_seen: 1'b0, ack_pos: 4'd0, ack_bad: 1'b0, phase: PH_BLANK,
    negative: 1'b0, value: 7'd0, too_large: 1'b0
  };

  function automatic logic [7:0] ack_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h41; // A
      4'd1:    ch = 8'h43; // C
      4'd2:    ch = 8'h4B; // K
      4'd3:    ch = 8'h5F; // _
      4'd4:    ch = 8'h52; // R
      4'd5:    ch = 8'h45; // E
      4'd6:    ch = 8'h43; // C
      4'd7:    ch = 8'h45; // E
      4'd8:    ch = 8'h49; // I
      4'd9:    ch = 8'h56; // V
      4'd10:   ch = 8'h45; // E
      4'd11:   ch = 8'h44; // D
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> hdl/uart_command_line_decoder.sv
// ----------------------------------------------------------------------------
// uart_command_line_decoder
// Builds command lines from received bytes and holds the latest command.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------
//   in      | in_valid / in_stall | in_req_type, in_rx_byte
//   out     | out_valid/out_stall | out_command, out_command_pending
//
// One item per cycle while neither channel stalls; the input register loads at accept
// and the line state update then lands in the result register when it advances.
// Synchronous active-low reset clears the line state and the pending command.
// A stalled result holds in the result register; the input register keeps
// taking items until it is full as well.
// ----------------------------------------------------------------------------
module uart_command_line_decoder
  import ucld_pkg::*;
#(
  parameter int unsigned MAX_LINE = 64
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_command,
  output logic       out_command_pending
);

  localparam int unsigned CNT_W = $clog2(MAX_LINE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LINE - 1);

  logic             in_valid_r;
  logic             req_r;
  logic [7:0]       byte_r;

  logic             out_valid_r, out_valid_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             pend_flag_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  parse_t           parse_r, parse_nxt;
  cmd_t             pend_r, pend_nxt;

  parse_t           parse_fed;
  cmd_t             line_cmd;

  logic             out_free;
  logic             advance;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  ucld_parser u_parser (
    .cur      (parse_r),
    .ch       (byte_r),
    .nxt      (parse_fed),
    .line_cmd (line_cmd)
  );

  always_comb begin
    count_nxt = count_r;
    parse_nxt = parse_r;
    pend_nxt  = pend_r;
    cmd_nxt   = CMD_NONE;
    if (req_r == REQ_TAKE) begin
      cmd_nxt  = pend_r;
      pend_nxt = CMD_NONE;
    end else if (byte_r == CH_LF) begin
      if (count_r != '0) begin
        pend_nxt = line_cmd;
      end
      count_nxt = '0;
      parse_nxt = PARSE_CLEAR;
    end else if ((byte_r != CH_CR) && (count_r != CNT_LAST)) begin
      count_nxt = count_r + CNT_W'(1);
      if (byte_r == CH_NUL) begin
        parse_nxt.zero_seen = 1'b1;
      end else if (!parse_r.zero_seen) begin
        parse_nxt = parse_fed;
      end
    end
  end

  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      parse_r     <= PARSE_CLEAR;
      pend_r      <= CMD_NONE;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        count_r <= count_nxt;
        parse_r <= parse_nxt;
        pend_r  <= pend_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r  <= in_req_type;
      byte_r <= in_rx_byte;
    end
    if (advance) begin
      cmd_r       <= cmd_nxt;
      pend_flag_r <= (pend_nxt != CMD_NONE);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_command         = cmd_r;
  assign out_command_pending = pend_flag_r;

endmodule

>>> hdl/ucld_parser.sv
// ----------------------------------------------------------------------------
// ucld_parser
// Per-character parser update and line-to-command mapping.
// ----------------------------------------------------------------------------
module ucld_parser
  import ucld_pkg::*;
(
  input  parse_t     cur,
  input  logic [7:0] ch,
  output parse_t     nxt,
  output cmd_t       line_cmd
);

  logic        digit;
  logic        blank;
  logic [3:0]  dval;
  logic [10:0] prod;
  logic        ack_done;

  assign digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VTAB) || (ch == CH_FF);
  assign dval  = 4'(ch - CH_ZERO);
  assign prod  = 11'({4'd0, cur.value} * 11'd10) + 11'(dval);

  always_comb begin
    nxt = cur;

    if (!cur.ack_bad) begin
      if ((cur.ack_pos < 4'(ACK_LEN)) && (ch == ack_char(cur.ack_pos))) begin
        nxt.ack_pos = cur.ack_pos + 4'd1;
      end else begin
        nxt.ack_bad = 1'b1;
      end
    end

    unique case (cur.phase)
      PH_BLANK: begin
        if (blank) begin
          nxt.phase = PH_BLANK;
        end else if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
          nxt.negative = (ch == CH_MINUS);
          nxt.phase    = PH_SIGN;
        end else if (!digit) begin
          nxt.phase = PH_BAD;
        end
      end
      PH_SIGN, PH_DIGIT: begin
        if (!digit) begin
          nxt.phase = PH_BAD;
        end
      end
      PH_BAD: nxt.phase = PH_BAD;
      default: nxt.phase = PH_BAD;
    endcase

    if (digit && (nxt.phase != PH_BAD)) begin
      nxt.phase = PH_DIGIT;
      if (cur.too_large || (prod > 11'(VAL_MAX))) begin
        nxt.too_large = 1'b1;
        nxt.value     = VAL_MAX;
      end else begin
        nxt.value = prod[6:0];
      end
    end
  end

  assign ack_done = !cur.ack_bad && (cur.ack_pos == 4'(ACK_LEN));

  always_comb begin
    if (ack_done) begin
      line_cmd = CMD_ACK;
    end else if ((cur.phase != PH_DIGIT) || cur.negative || cur.too_large) begin
      line_cmd = CMD_UNKNOWN;
    end else begin
      unique case (cur.value)
        VAL_STOP:  line_cmd = CMD_STOP_CAL;
        VAL_START: line_cmd = CMD_START_CAL;
        VAL_OFF:   line_cmd = CMD_OFF;
        VAL_LON:   line_cmd = CMD_LASER_ON;
        VAL_LOFF:  line_cmd = CMD_LASER_OFF;
        VAL_SHOT:  line_cmd = CMD_SHOT;
        default:   line_cmd = CMD_UNKNOWN;
      endcase
    end
  end

endmodule

>>> sim/command_line_monitor.sv
// ----------------------------------------------------------------------------
// command_line_monitor
// Watches both channels of the command line decoder. Every accepted input
// item runs through a local line parser that works out the result it causes;
// every accepted result is compared with the oldest result still owed.
// ----------------------------------------------------------------------------
module command_line_monitor
  import ucld_pkg::*;
#(
  parameter int unsigned MAX_LINE = 64
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] out_command,
  input  logic       out_command_pending,
  output int         n_errors,
  output int         n_waiting,
  output int         n_handed
);

  typedef struct packed {
    cmd_t command;
    logic pending;
  } reply_t;

  int unsigned line_len;
  logic        nul_seen;
  int unsigned ack_pos;
  logic        ack_bad;
  phase_t      phase;
  logic        negative;
  int unsigned value;
  logic        too_large;
  cmd_t        held_cmd;

  reply_t owed_replies[$];

  function automatic void start_line();
    line_len  = 0;
    nul_seen  = 1'b0;
    ack_pos   = 0;
    ack_bad   = 1'b0;
    phase     = PH_BLANK;
    negative  = 1'b0;
    value     = 0;
    too_large = 1'b0;
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    logic        is_digit;
    logic        is_blank;
    int unsigned acc;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FF);

    if (!ack_bad) begin
      if (ack_pos < ACK_LEN && c == ack_char(4'(ack_pos)))
        ack_pos++;
      else
        ack_bad = 1'b1;
    end

    case (phase)
      PH_BLANK: begin
        if (!is_blank) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            negative = (c == CH_MINUS);
            phase    = PH_SIGN;
          end else if (!is_digit) begin
            phase = PH_BAD;
          end
        end
      end
      PH_SIGN, PH_DIGIT: begin
        if (!is_digit)
          phase = PH_BAD;
      end
      default: ;
    endcase

    if (is_digit && phase != PH_BAD) begin
      acc   = value * 10 + (c - CH_ZERO);
      phase = PH_DIGIT;
      // saturate, the line then can only give unknown
      if (too_large || acc > VAL_MAX) begin
        too_large = 1'b1;
        value     = VAL_MAX;
      end else begin
        value = acc;
      end
    end
  endfunction

  function automatic cmd_t decode_line();
    if (!ack_bad && ack_pos == ACK_LEN)
      return CMD_ACK;
    if (phase != PH_DIGIT || negative || too_large)
      return CMD_UNKNOWN;
    case (value)
      VAL_STOP:  return CMD_STOP_CAL;
      VAL_START: return CMD_START_CAL;
      VAL_OFF:   return CMD_OFF;
      VAL_LON:   return CMD_LASER_ON;
      VAL_LOFF:  return CMD_LASER_OFF;
      VAL_SHOT:  return CMD_SHOT;
      default:   return CMD_UNKNOWN;
    endcase
  endfunction

  function automatic reply_t predict_reply(input logic req, input logic [7:0] c);
    reply_t r;
    r.command = CMD_NONE;
    if (req == REQ_TAKE) begin
      r.command = held_cmd;
      held_cmd  = CMD_NONE;
    end else if (c == CH_LF) begin
      if (line_len > 0)
        held_cmd = decode_line();
      start_line();
    end else if (c != CH_CR && line_len < MAX_LINE - 1) begin
      line_len++;
      if (c == CH_NUL)
        nul_seen = 1'b1;
      else if (!nul_seen)
        absorb_char(c);
    end
    r.pending = (held_cmd != CMD_NONE);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      start_line();
      held_cmd = CMD_NONE;
      owed_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_replies.size() == 0) begin
          $error("unexpected result: out_command %0d, out_command_pending %0b",
                 out_command, out_command_pending);
          n_errors++;
        end else begin
          want = owed_replies.pop_front();
          if (out_command !== want.command) begin
            $error("out_command: expected %0d, got %0d", want.command, out_command);
            n_errors++;
          end
          if (out_command_pending !== want.pending) begin
            $error("out_command_pending: expected %0b, got %0b",
                   want.pending, out_command_pending);
            n_errors++;
          end
          if (want.command != CMD_NONE)
            n_handed++;
        end
      end
      if (in_valid && !in_stall)
        owed_replies.push_back(predict_reply(in_req_type, in_rx_byte));
    end
    n_waiting <= owed_replies.size();
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds the command line decoder with text lines and take requests: a short
// directed opening, then random lines (codes, acks, near misses, signed and
// oversized numbers, zero bytes, overlong lines, noise) under four mixes of
// sender gaps and receiver stalls. The monitor does all result checking.
// ----------------------------------------------------------------------------
module testbench;
  import ucld_pkg::*;

  localparam int unsigned LINE_MAX     = 64;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DIRECTED     = 25;
  localparam int          RANDOM_ITEMS = 1575;

  localparam logic [6:0] CODES [6] = '{VAL_STOP, VAL_START, VAL_OFF,
                                       VAL_LON, VAL_LOFF, VAL_SHOT};

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_req_type = REQ_BYTE;
  logic [7:0] in_rx_byte  = 8'h00;
  logic       out_stall   = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [3:0] out_command;
  logic       out_command_pending;

  int n_errors;
  int n_waiting;
  int n_handed;
  int items_sent;
  int lines_sent;
  int cycle_count;
  int sender_idle_pct;
  int receiver_stall_pct;

  logic [7:0] line_text[$];

  always #4 clk = ~clk;

  uart_command_line_decoder #(
    .MAX_LINE(LINE_MAX)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command        (out_command),
    .out_command_pending(out_command_pending)
  );

  command_line_monitor #(
    .MAX_LINE(LINE_MAX)
  ) u_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command        (out_command),
    .out_command_pending(out_command_pending),
    .n_errors           (n_errors),
    .n_waiting          (n_waiting),
    .n_handed           (n_handed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, n_waiting);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    out_stall <= rst_n && ($urandom_range(0, 99) < receiver_stall_pct);

  task automatic send_item(input logic rq, input logic [7:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= rq;
    in_rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic take_command();
    send_item(REQ_TAKE, 8'($urandom_range(0, 255)));
  endtask

  // hold off until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_waiting != 0);
  endtask

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VTAB;
      default: return CH_FF;
    endcase
  endfunction

  task automatic add_blanks(input int unsigned n);
    repeat (n) line_text.push_back(random_blank());
  endtask

  task automatic add_number(input int unsigned v);
    int unsigned div;
    div = 1;
    while (div * 10 <= v) div *= 10;
    while (div > 0) begin
      line_text.push_back(8'(CH_ZERO + (v / div) % 10));
      div /= 10;
    end
  endtask

  task automatic add_ack(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      line_text.push_back(ack_char(4'(i)));
  endtask

  task automatic make_line();
    int          pick;
    int unsigned n;
    int unsigned pos;
    logic [6:0]  code;
    line_text.delete();
    pick = $urandom_range(0, 99);
    code = CODES[$urandom_range(0, 5)];
    if (pick < 30) begin
      add_blanks($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0)
        line_text.push_back(CH_PLUS);
      repeat ($urandom_range(0, 2)) line_text.push_back(CH_ZERO);
      add_number(code);
    end else if (pick < 45) begin
      add_ack(ACK_LEN);
    end else if (pick < 55) begin
      // ack near misses: cut short, trailing junk, one bit off
      n = $urandom_range(1, ACK_LEN);
      add_ack(n);
      case ($urandom_range(0, 2))
        0: line_text.push_back(8'($urandom_range(0, 255)));
        1: begin
          pos = $urandom_range(0, n - 1);
          line_text[pos] = line_text[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        default: ;
      endcase
    end else if (pick < 70) begin
      if ($urandom_range(0, 3) == 0)
        line_text.push_back(CH_MINUS);
      case ($urandom_range(0, 2))
        0:       add_number(code);
        1:       add_number($urandom_range(0, 200));
        default: add_number($urandom_range(1000, 99999));
      endcase
    end else if (pick < 78) begin
      add_blanks($urandom_range(0, 2));
      if ($urandom_range(0, 1))
        line_text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      if ($urandom_range(0, 1))
        add_number(code);
      case ($urandom_range(0, 2))
        0:       line_text.push_back(random_blank());
        1:       line_text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        default: line_text.push_back(8'($urandom_range(8'h3A, 8'h7E)));
      endcase
      add_number(code);
    end else if (pick < 84) begin
      // zero byte cuts the parsed text wherever it lands
      add_number(code);
      pos = $urandom_range(0, line_text.size());
      line_text.insert(pos, CH_NUL);
    end else if (pick < 88) begin
      if ($urandom_range(0, 1))
        line_text.push_back(CH_CR);
    end else if (pick < 94) begin
      // digits land around the stored-length limit
      add_blanks($urandom_range(LINE_MAX - 6, LINE_MAX + 4));
      add_number(code);
    end else begin
      repeat ($urandom_range(1, 8)) line_text.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_line();
    foreach (line_text[i]) begin
      if ($urandom_range(0, 99) < 5)
        send_item(REQ_BYTE, CH_CR);
      if ($urandom_range(0, 99) < 6)
        take_command();
      send_item(REQ_BYTE, line_text[i]);
    end
    if ($urandom_range(0, 3) == 0)
      send_item(REQ_BYTE, CH_CR);
    send_item(REQ_BYTE, CH_LF);
    lines_sent++;
    if ($urandom_range(0, 1))
      take_command();
  endtask

  initial begin
    int goal;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(REQ_TAKE, 8'hFF);            // nothing pending yet
    send_item(REQ_BYTE, "4");
    send_item(REQ_BYTE, "8");
    send_item(REQ_BYTE, CH_LF);
    send_item(REQ_TAKE, 8'h00);
    send_item(REQ_BYTE, CH_MINUS);         // negative with a dropped carriage return
    send_item(REQ_BYTE, "5");
    send_item(REQ_BYTE, CH_CR);
    send_item(REQ_BYTE, CH_LF);
    send_item(REQ_TAKE, 8'hAA);
    send_item(REQ_BYTE, CH_NUL);           // line opening with a zero byte
    send_item(REQ_BYTE, CH_LF);
    send_item(REQ_BYTE, CH_LF);            // empty line keeps the pending command
    send_item(REQ_TAKE, 8'h55);
    send_item(REQ_TAKE, 8'hFF);
    send_item(REQ_BYTE, "9");
    send_item(REQ_BYTE, "9");
    send_item(REQ_BYTE, "9");
    send_item(REQ_BYTE, CH_LF);
    send_item(REQ_BYTE, "5");              // replaces the unknown still pending
    send_item(REQ_BYTE, "6");
    send_item(REQ_BYTE, CH_LF);
    send_item(REQ_BYTE, 8'hFF);
    send_item(REQ_BYTE, CH_LF);
    send_item(REQ_TAKE, 8'h7F);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 49;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 49;
        end
        default: begin
          sender_idle_pct    = 18;
          receiver_stall_pct = 18;
        end
      endcase
      goal = DIRECTED + (ph + 1) * RANDOM_ITEMS / 4;
      while (items_sent < goal) begin
        make_line();
        send_line();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("sent %0d items in %0d lines: codes, acks and near misses, signs, big values,",
             items_sent, lines_sent);
    $display("zero bytes, overlong lines and noise under four gap/stall mixes; %0d commands taken",
             n_handed);
    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hdl/ucld_pkg.sv
hdl/ucld_parser.sv
hdl/uart_command_line_decoder.sv
sim/command_line_monitor.sv
sim/testbench.sv
